FILE: src/compass_heading_steer_defines.svh
// Assertion macros shared by the compass heading steering RTL.
`ifndef COMPASS_HEADING_STEER_DEFINES_SVH
`define COMPASS_HEADING_STEER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CHS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define CHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/chs_pkg.sv
// Package with types, widths, constants and the arctangent table of the heading steer block.
`default_nettype none
package chs_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int FRAC_BITS_DEF     = 6;
  localparam int TABLE_LEN         = 24;

  localparam int MAG_W     = 16;
  localparam int HEADING_W = 15;
  localparam int CMD_W     = 2;
  localparam int DEG_W     = 9;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Vector datapath width: 17-bit magnitude, times 256, CORDIC gain and headroom.
  localparam int VEC_W = 28;
  // Angle width: degrees with 16 fraction bits, signed.
  localparam int ANG_W    = 27;
  localparam int ANG_FRAC = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_NONE    = 2'd0,
    CMD_ALIGNED = 2'd1,
    CMD_RIGHT   = 2'd2,
    CMD_LEFT    = 2'd3
  } turn_cmd_t;

  typedef enum logic [0:0] {
    REG_TARGET_HEADING = 1'b0
  } reg_idx_t;

  // atan(2^-i) in degrees with 16 fraction bits, rounded to nearest.
  function automatic logic signed [ANG_W-1:0] atan_q16(input int idx);
    logic signed [ANG_W-1:0] v;
    case (idx)
      0:  v = ANG_W'(2949120);
      1:  v = ANG_W'(1740967);
      2:  v = ANG_W'(919879);
      3:  v = ANG_W'(466945);
      4:  v = ANG_W'(234379);
      5:  v = ANG_W'(117304);
      6:  v = ANG_W'(58666);
      7:  v = ANG_W'(29335);
      8:  v = ANG_W'(14668);
      9:  v = ANG_W'(7334);
      10: v = ANG_W'(3667);
      11: v = ANG_W'(1833);
      12: v = ANG_W'(917);
      13: v = ANG_W'(458);
      14: v = ANG_W'(229);
      15: v = ANG_W'(115);
      16: v = ANG_W'(57);
      17: v = ANG_W'(29);
      18: v = ANG_W'(14);
      19: v = ANG_W'(7);
      20: v = ANG_W'(4);
      21: v = ANG_W'(2);
      22: v = ANG_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: src/compass_heading_steer.sv
// Heading from a magnetometer sample through a pipelined CORDIC, and a steering decision.
// Path: quadrant fold register, one register per CORDIC stage, P1, P2, then the output register.
// Throughput: one word per cycle unless the output side stalls; every CORDIC iteration is a pipeline stage of its own.
// The pipeline moves as one whenever the output register is empty or being taken.
// Reset (synchronous, rst_n low) clears all valid bits and sets target_heading to 0.
// The pipeline holds its contents while the output side stalls; nothing is dropped.
`default_nettype none
`include "compass_heading_steer_defines.svh"
module compass_heading_steer #(
  parameter int CORDIC_STAGES         = chs_pkg::CORDIC_STAGES_DEF,
  parameter int HEADING_FRACTION_BITS = chs_pkg::FRAC_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // [15:0] mag_x, [31:16] mag_y
  input  wire  [chs_pkg::IN_DATA_W-1:0]       in_tdata,
  // [0] steer_enable
  input  wire  [0:0]                          in_tuser,
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // [14:0] heading, [16:15] turn_command, [25:17] reverse_heading, [31:26] zero
  output logic [chs_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [chs_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire  [chs_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [chs_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int VW   = chs_pkg::VEC_W;
  localparam int AW   = chs_pkg::ANG_W;
  localparam int F    = HEADING_FRACTION_BITS;
  localparam int DROP = chs_pkg::ANG_FRAC - F;
  localparam int HW   = F + chs_pkg::DEG_W;
  localparam int NS   = (CORDIC_STAGES < chs_pkg::TABLE_LEN) ? CORDIC_STAGES
                                                              : chs_pkg::TABLE_LEN;

  localparam logic signed [AW-1:0] ANG_90  = AW'(90 * (1 << chs_pkg::ANG_FRAC));
  localparam logic signed [AW-1:0] ANG_180 = AW'(180 * (1 << chs_pkg::ANG_FRAC));
  localparam logic signed [AW-1:0] ANG_270 = AW'(270 * (1 << chs_pkg::ANG_FRAC));
  localparam logic signed [AW-1:0] ANG_360 = AW'(360 * (1 << chs_pkg::ANG_FRAC));
  localparam logic signed [AW-1:0] ANG_HALF_UNIT = AW'(1 << (DROP - 1));

  localparam logic [HW-1:0] H_MAX     = HW'(360 << F);
  localparam logic [HW-1:0] H_180     = HW'(180 << F);
  localparam logic [HW-1:0] TWO_DEG   = HW'(2 << F);
  localparam logic [HW-1:0] DEG_181   = HW'(181 << F);
  localparam logic [HW-1:0] DEG_361   = HW'(361 << F);

  typedef enum logic [1:0] {
    AX_90  = 2'd0,
    AX_180 = 2'd1,
    AX_270 = 2'd2,
    AX_360 = 2'd3
  } axis_t;

  // ---------------------------------------------------------------- config
  logic [chs_pkg::DEG_W-1:0] target_r;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
    end else if (cfg_wr &&
                 paddr[chs_pkg::APB_ADDR_W-1:2] == chs_pkg::REG_TARGET_HEADING) begin
      target_r <= pwdata[chs_pkg::DEG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[chs_pkg::APB_ADDR_W-1:2] == chs_pkg::REG_TARGET_HEADING) begin
      prdata = chs_pkg::APB_DATA_W'(target_r);
    end
  end

  // ---------------------------------------------------------------- flow control
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // ---------------------------------------------------------------- stage 0: quadrant fold
  logic                 v_r    [0:NS];
  logic                 en_r   [0:NS];
  logic                 ax_r   [0:NS];
  axis_t                axc_r  [0:NS];
  logic signed [VW-1:0] x_r    [0:NS];
  logic signed [VW-1:0] y_r    [0:NS];
  logic signed [AW-1:0] z_r    [0:NS];

  logic signed [chs_pkg::MAG_W-1:0] in_x, in_y;
  logic signed [chs_pkg::MAG_W:0]   fx, fy;
  logic                             ax_nxt;
  axis_t                            axc_nxt;

  assign in_x = in_tdata[chs_pkg::MAG_W-1:0];
  assign in_y = in_tdata[2*chs_pkg::MAG_W-1:chs_pkg::MAG_W];

  always_comb begin
    // The left half plane is folded to the right one; the angle starts at 180 degrees.
    if (in_x < 0) begin
      fx = -(chs_pkg::MAG_W+1)'(in_x);
      fy = -(chs_pkg::MAG_W+1)'(in_y);
    end else begin
      fx = (chs_pkg::MAG_W+1)'(in_x);
      fy = (chs_pkg::MAG_W+1)'(in_y);
    end
    ax_nxt = (in_x == 0) || (in_y == 0);
    if (in_y == 0) begin
      axc_nxt = (in_x < 0) ? AX_360 : AX_180;
    end else begin
      axc_nxt = (in_y > 0) ? AX_270 : AX_90;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      en_r[0]  <= in_tuser[0];
      ax_r[0]  <= ax_nxt;
      axc_r[0] <= axc_nxt;
      x_r[0]   <= VW'(fx) <<< 8;
      y_r[0]   <= VW'(fy) <<< 8;
      z_r[0]   <= (in_x < 0) ? ANG_180 : '0;
    end
  end

  // ---------------------------------------------------------------- CORDIC stages
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    logic signed [VW-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        en_r[i+1]  <= en_r[i];
        ax_r[i+1]  <= ax_r[i];
        axc_r[i+1] <= axc_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + chs_pkg::atan_q16(i);
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - chs_pkg::atan_q16(i);
        end
      end
    end
  end

  // ---------------------------------------------------------------- P1: wrap and offset
  logic                 p1_v_r, p1_en_r;
  logic signed [AW-1:0] p1_hq_r, p1_hq_nxt;

  always_comb begin
    if (ax_r[NS]) begin
      case (axc_r[NS])
        AX_90:   p1_hq_nxt = ANG_90;
        AX_180:  p1_hq_nxt = ANG_180;
        AX_270:  p1_hq_nxt = ANG_270;
        AX_360:  p1_hq_nxt = ANG_360;
        default: p1_hq_nxt = ANG_180;
      endcase
    end else if (z_r[NS] > ANG_180) begin
      // Wrapping by 360 and adding 180 is one subtraction of 180.
      p1_hq_nxt = z_r[NS] - ANG_180;
    end else begin
      p1_hq_nxt = z_r[NS] + ANG_180;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (adv) begin
      p1_v_r <= v_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_en_r <= en_r[NS];
      p1_hq_r <= p1_hq_nxt;
    end
  end

  // ---------------------------------------------------------------- P2: round to heading units
  logic                 p2_v_r, p2_en_r;
  logic [HW-1:0]        p2_h_r, p2_h_nxt;
  logic signed [AW-1:0] hq_pos, hq_rnd;

  always_comb begin
    hq_pos = (p1_hq_r < 0) ? '0 : p1_hq_r;
    hq_rnd = (hq_pos + ANG_HALF_UNIT) >>> DROP;
    if (hq_rnd > AW'(H_MAX)) begin
      p2_h_nxt = H_MAX;
    end else begin
      p2_h_nxt = hq_rnd[HW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (adv) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_en_r <= p1_en_r;
      p2_h_r  <= p2_h_nxt;
    end
  end

  // ---------------------------------------------------------------- P3: decision, output word
  logic [HW-1:0]               tgt, diff;
  logic [HW:0]                 rsum;
  chs_pkg::turn_cmd_t          cmd_nxt, cmd_r;
  logic [chs_pkg::DEG_W-1:0]   rev_nxt, rev_r;
  logic [HW-1:0]               head_r;

  always_comb begin
    tgt  = HW'(target_r) << F;
    diff = (tgt > p2_h_r) ? (tgt - p2_h_r) : (p2_h_r - tgt);
    if (p2_h_r <= H_180) begin
      rsum = (HW+1)'(p2_h_r) + (HW+1)'(H_180);
    end else begin
      rsum = (HW+1)'(p2_h_r) - (HW+1)'(H_180);
    end
    rev_nxt = chs_pkg::DEG_W'(rsum >> F);
    cmd_nxt = chs_pkg::CMD_NONE;
    if (p2_en_r) begin
      if (diff < TWO_DEG) begin
        cmd_nxt = chs_pkg::CMD_ALIGNED;
      end else if (diff < DEG_181) begin
        cmd_nxt = (p2_h_r < tgt) ? chs_pkg::CMD_RIGHT : chs_pkg::CMD_LEFT;
      end else if (diff < DEG_361) begin
        // The long way round is shorter the other direction.
        cmd_nxt = (p2_h_r > tgt) ? chs_pkg::CMD_RIGHT : chs_pkg::CMD_LEFT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (adv) begin
      out_tvalid <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      head_r <= p2_h_r;
      cmd_r  <= cmd_nxt;
      rev_r  <= rev_nxt;
    end
  end

  assign out_tdata = chs_pkg::OUT_DATA_W'({rev_r, cmd_r, chs_pkg::HEADING_W'(head_r)});

  // ---------------------------------------------------------------- assertions
  `CHS_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, v_r[0], "accepted word lost at entry")
  `CHS_ASSERT_NEXT(a_last_to_out, adv && p2_v_r, out_tvalid, "word lost at output register")
  `CHS_ASSERT_NOW(a_heading_range, out_tvalid, head_r <= H_MAX, "heading above 360 degrees")
  `CHS_ASSERT_NOW(a_disabled_none, p2_v_r && !p2_en_r, cmd_nxt == chs_pkg::CMD_NONE,
                  "command given while steering disabled")

endmodule
`default_nettype wire
